FILE: hw/rtl/gqg_pkg.sv
// Shared types, constants and helper functions for the glyph quad generator.
// Used by every module of the block; depends on nothing else.
package gqg_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int TIDX_W      = $clog2(TABLE_DEPTH);

  // Depth of the queue of classified draw items between front and back.
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = QPTR_W + 1;

  // Depth of the vertex queue on the result side.
  localparam int OQ_DEPTH = 2;
  localparam int OQPTR_W  = $clog2(OQ_DEPTH);
  localparam int OQCNT_W  = OQPTR_W + 1;

  // Shared divider: signed dividend, unsigned divisor, clamped quotient.
  localparam int DIV_NUM_W = 64;
  localparam int DIV_DEN_W = 43;
  localparam int DIV_Q_W   = 25;
  localparam int DIV_RES_W = DIV_Q_W + 2;
  localparam int DIV_DS_W  = DIV_DEN_W + DIV_Q_W - 1;
  localparam int DIV_CNT_W = $clog2(DIV_Q_W);

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_COLUMNS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ATLAS_ROWS    = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CODE    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LAST_CODE     = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_CODE = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FIXED_WIDTH   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH    = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT   = 4'd7;

  localparam logic KIND_DRAW = 1'b0;
  localparam logic KIND_LOAD = 1'b1;

  localparam logic [2:0] LAST_VTX = 3'd5;

  // Configuration as seen by the datapath; zero divisors already read as one.
  typedef struct packed {
    logic [8:0]  cols;
    logic [8:0]  rows;
    logic [7:0]  first_code;
    logic [7:0]  last_code;
    logic [7:0]  fallback_code;
    logic        fixed_width;
    logic [11:0] cell_w;
    logic [11:0] cell_h;
  } cfg_t;

  typedef struct packed {
    logic [7:0]         idx;
    logic [11:0]        width;
    logic               line_start;
    logic signed [23:0] start_x;
    logic signed [23:0] start_y;
    logic [19:0]        glyph_h;
    logic [31:0]        color;
    logic [15:0]        vp_w;
    logic [15:0]        vp_h;
  } draw_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        tex_u;
    logic [15:0]        tex_v;
    logic [31:0]        color;
    logic signed [23:0] pen_after;
    logic               last;
  } vertex_t;

  typedef enum logic [3:0] {
    DS_COL, DS_U0, DS_U1, DS_V0, DS_V1, DS_X0, DS_X1, DS_YB, DS_YT, DS_ADV
  } div_sel_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL_RDCH, ST_MUL_RNCW, ST_MUL_A, ST_MUL_B, ST_MUL_DQ, ST_MUL_HW,
    ST_DIV_SETUP, ST_DIV_START, ST_DIV_WAIT, ST_MUL_COLRD, ST_MUL_COLSRD,
    ST_PEN, ST_EMIT
  } back_state_e;

  function automatic div_sel_e div_sel_next(input div_sel_e s);
    div_sel_e n;
    case (s)
      DS_COL:  n = DS_U0;
      DS_U0:   n = DS_U1;
      DS_U1:   n = DS_V0;
      DS_V0:   n = DS_V1;
      DS_V1:   n = DS_X0;
      DS_X0:   n = DS_X1;
      DS_X1:   n = DS_YB;
      DS_YB:   n = DS_YT;
      DS_YT:   n = DS_ADV;
      default: n = DS_COL;
    endcase
    return n;
  endfunction

  // Quad corner visited by each of the six vertices of a glyph.
  function automatic logic [1:0] corner_of(input logic [2:0] k);
    logic [1:0] c;
    case (k)
      3'd0:    c = 2'd0;
      3'd1:    c = 2'd1;
      3'd2:    c = 2'd2;
      3'd3:    c = 2'd2;
      3'd4:    c = 2'd3;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

  function automatic logic signed [15:0] sat_s16(input logic signed [DIV_RES_W-1:0] v);
    logic signed [DIV_RES_W-1:0] hi;
    logic signed [DIV_RES_W-1:0] lo;
    hi = DIV_RES_W'(32767);
    lo = -DIV_RES_W'(32768);
    if (v > hi) return 16'sh7fff;
    if (v < lo) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic [15:0] sat_u16(input logic signed [DIV_RES_W-1:0] v);
    logic signed [DIV_RES_W-1:0] hi;
    hi = DIV_RES_W'(65535);
    if (v < 0) return 16'h0000;
    if (v > hi) return 16'hffff;
    return v[15:0];
  endfunction

endpackage

FILE: hw/rtl/gqg_div.sv
// Shared restoring divider of the glyph quad generator, one quotient bit a cycle.
// Depends on gqg_pkg for its widths.
module gqg_div import gqg_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic signed [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0]        den_i,
  output logic                        done_o,
  output logic signed [DIV_RES_W-1:0] quot_o,
  output logic [DIV_DEN_W-1:0]        rem_o
);

  logic                 busy_q, done_q, neg_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_NUM_W-1:0] rem_q;
  logic [DIV_DS_W-1:0]  ds_q;
  logic [DIV_Q_W-1:0]   qm_q;

  logic                 neg_d;
  logic [DIV_NUM_W-1:0] mag;
  logic                 over;
  logic                 ge;
  logic [DIV_Q_W:0]     qadj;

  assign neg_d = num_i[DIV_NUM_W-1];
  assign mag   = neg_d ? DIV_NUM_W'(-num_i) : DIV_NUM_W'(num_i);
  // Quotients that cannot fit the clamp width are pinned at the largest magnitude.
  assign over  = (mag >> DIV_Q_W) >= DIV_NUM_W'(den_i);
  assign ge    = DIV_DS_W'(rem_q) >= ds_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        neg_q <= neg_d;
        if (over) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= DIV_CNT_W'(DIV_Q_W - 1);
        end
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (over) begin
        qm_q  <= '1;
        rem_q <= '0;
      end else begin
        qm_q  <= '0;
        rem_q <= mag;
        ds_q  <= {den_i, {(DIV_Q_W-1){1'b0}}};
      end
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - DIV_NUM_W'(ds_q);
      end
      qm_q <= {qm_q[DIV_Q_W-2:0], ge};
      ds_q <= ds_q >> 1;
    end
  end

  // Floor for negative dividends: one more step down when anything is left over.
  assign qadj   = {1'b0, qm_q} + (DIV_Q_W+1)'(neg_q && (rem_q != '0));
  assign quot_o = neg_q ? -$signed(DIV_RES_W'(qadj)) : $signed(DIV_RES_W'(qadj));
  assign rem_o  = rem_q[DIV_DEN_W-1:0];
  assign done_o = done_q;

endmodule

FILE: hw/rtl/gqg_front.sv
// Front end of the glyph quad generator: accepts items, keeps the glyph width
// table, maps codes to atlas cells and queues draw items. Depends on gqg_pkg.
module gqg_front import gqg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               push,
  output logic               full,
  input  logic               kind_i,
  input  logic [7:0]         char_code_i,
  input  logic [11:0]        width_value_i,
  input  logic               line_start_i,
  input  logic signed [23:0] start_x_i,
  input  logic signed [23:0] start_y_i,
  input  logic [19:0]        glyph_height_i,
  input  logic [31:0]        color_i,
  input  logic [15:0]        viewport_width_i,
  input  logic [15:0]        viewport_height_i,
  output logic               q_valid_o,
  input  logic               q_pop_i,
  output draw_t              q_data_o
);

  logic [11:0] width_mem [TABLE_DEPTH];
  logic [11:0] rd_q;

  logic        s1_valid_q;
  draw_t       s1_rec_q;
  draw_t       s1_rec_d;
  draw_t       push_data;

  draw_t       qmem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;

  logic        accept, acc_draw, acc_load;
  logic [7:0]  code_sel;
  logic [7:0]  idx;
  logic        q_pop;

  assign full     = (cnt_q + QCNT_W'(s1_valid_q)) >= QCNT_W'(QDEPTH);
  assign accept   = push && !full;
  assign acc_draw = accept && (kind_i == KIND_DRAW);
  assign acc_load = accept && (kind_i == KIND_LOAD);

  // Codes outside the atlas range draw the fallback glyph; the offset wraps at 8 bits.
  assign code_sel = ((char_code_i < cfg_i.first_code) || (char_code_i > cfg_i.last_code))
                    ? cfg_i.fallback_code : char_code_i;
  assign idx      = code_sel - cfg_i.first_code;

  always_comb begin
    s1_rec_d            = '0;
    s1_rec_d.idx        = idx;
    s1_rec_d.line_start = line_start_i;
    s1_rec_d.start_x    = start_x_i;
    s1_rec_d.start_y    = start_y_i;
    s1_rec_d.glyph_h    = glyph_height_i;
    s1_rec_d.color      = color_i;
    s1_rec_d.vp_w       = (viewport_width_i == '0) ? 16'd1 : viewport_width_i;
    s1_rec_d.vp_h       = (viewport_height_i == '0) ? 16'd1 : viewport_height_i;
  end

  always_ff @(posedge clk_i) begin
    if (acc_load && ({1'b0, char_code_i} < 9'(TABLE_DEPTH))) begin
      width_mem[char_code_i[TIDX_W-1:0]] <= width_value_i;
    end
    if (acc_draw) begin
      rd_q     <= width_mem[idx[TIDX_W-1:0]];
      s1_rec_q <= s1_rec_d;
    end
  end

  always_comb begin
    push_data       = s1_rec_q;
    push_data.width = rd_q;
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_pop     = q_pop_i && q_valid_o;
  assign q_data_o  = qmem[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      qmem[wr_ptr_q] <= push_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      cnt_q      <= '0;
    end else begin
      s1_valid_q <= acc_draw;
      if (s1_valid_q) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + QCNT_W'(s1_valid_q) - QCNT_W'(q_pop);
    end
  end

endmodule

FILE: hw/rtl/gqg_back.sv
// Back end of the glyph quad generator: works out the quad of one draw item
// with the shared divider and queues its six vertices. Depends on gqg_pkg, gqg_div.
module gqg_back import gqg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               q_valid_i,
  output logic               q_pop_o,
  input  draw_t              q_data_i,
  output logic               empty,
  input  logic               pop,
  output vertex_t            vtx_o
);

  back_state_e state_q, state_d;
  div_sel_e    sel_q;
  logic [2:0]  vtx_q;

  draw_t              rec_q;
  logic signed [23:0] pen_q;
  logic [23:0]        p_rdch_q, p_rncw_q;
  logic signed [48:0] p_a_q;
  logic [43:0]        p_b_q;
  logic [39:0]        p_dq_q;
  logic [31:0]        p_hw_q;
  logic [20:0]        p_colrd_q, p_colsrd_q;
  logic [8:0]         col_q;
  logic signed [10:0] row_q;
  logic [15:0]        u0_q, u1_q, v0_q, v1_q;
  logic signed [15:0] x0_q, x1_q, yb_q, yt_q;
  logic signed [DIV_RES_W-1:0] adv_q;

  logic signed [DIV_NUM_W-1:0] t_q, t_d;
  logic [DIV_DEN_W-1:0]        dd_q, dd_d;

  logic                        div_start, div_done;
  logic signed [DIV_RES_W-1:0] div_q;
  logic [DIV_DEN_W-1:0]        div_rem;

  logic [11:0] rd, rn;
  logic signed [63:0] s_col, s_cols, s_rows, s_row, s_colrd, s_colsrd, s_rn;
  logic signed [63:0] s_x, s_y, s_h, s_vw, s_vh, s_a, s_b, s_dq, s_hw, s_cw;
  logic signed [27:0] pen_sum;

  vertex_t             oq [OQ_DEPTH];
  logic [OQPTR_W-1:0]  oq_wr_q, oq_rd_q;
  logic [OQCNT_W-1:0]  oq_cnt_q;
  logic                oq_push, oq_pop, oq_full;
  vertex_t             vtx_new;
  logic [1:0]          crn;

  gqg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (t_q),
    .den_i   (dd_q),
    .done_o  (div_done),
    .quot_o  (div_q),
    .rem_o   (div_rem)
  );

  assign rd = cfg_i.fixed_width ? cfg_i.cell_w : 12'd1;
  assign rn = cfg_i.fixed_width ? rec_q.width : 12'd1;

  assign s_col    = $signed(64'(col_q));
  assign s_cols   = $signed(64'(cfg_i.cols));
  assign s_rows   = $signed(64'(cfg_i.rows));
  assign s_row    = 64'(row_q);
  assign s_colrd  = $signed(64'(p_colrd_q));
  assign s_colsrd = $signed(64'(p_colsrd_q));
  assign s_rn     = $signed(64'(rn));
  assign s_x      = 64'(pen_q);
  assign s_y      = 64'(rec_q.start_y);
  assign s_h      = $signed(64'(rec_q.glyph_h));
  assign s_vw     = $signed(64'(rec_q.vp_w));
  assign s_vh     = $signed(64'(rec_q.vp_h));
  assign s_a      = 64'(p_a_q);
  assign s_b      = $signed(64'(p_b_q));
  assign s_dq     = $signed(64'(p_dq_q));
  assign s_hw     = $signed(64'(p_hw_q));
  assign s_cw     = $signed(64'(cfg_i.cell_w));

  // Every rounded quotient is floor((2n + d) / 2d), which rounds ties upwards.
  always_comb begin
    case (sel_q)
      DS_COL: begin
        t_d  = $signed(64'(rec_q.idx));
        dd_d = DIV_DEN_W'(cfg_i.cols);
      end
      DS_U0: begin
        t_d  = (s_col <<< 16) + s_cols;
        dd_d = DIV_DEN_W'({cfg_i.cols, 1'b0});
      end
      DS_U1: begin
        t_d  = ((s_colrd + s_rn) <<< 16) + s_colsrd;
        dd_d = DIV_DEN_W'({p_colsrd_q, 1'b0});
      end
      DS_V0: begin
        t_d  = (s_row <<< 16) + s_rows;
        dd_d = DIV_DEN_W'({cfg_i.rows, 1'b0});
      end
      DS_V1: begin
        t_d  = ((s_row + 64'sd1) <<< 16) + s_rows;
        dd_d = DIV_DEN_W'({cfg_i.rows, 1'b0});
      end
      DS_X0: begin
        t_d  = (s_x <<< 8) - (s_vw <<< 15) + s_vw;
        dd_d = DIV_DEN_W'({rec_q.vp_w, 1'b0});
      end
      DS_X1: begin
        t_d  = ((s_a + s_b) <<< 8) - (s_dq <<< 15) + s_dq;
        dd_d = DIV_DEN_W'({p_dq_q, 1'b0});
      end
      DS_YB: begin
        t_d  = (s_vh <<< 15) + s_vh - ((s_y + s_h) <<< 8);
        dd_d = DIV_DEN_W'({rec_q.vp_h, 1'b0});
      end
      DS_YT: begin
        t_d  = (s_vh <<< 15) + s_vh - (s_y <<< 8);
        dd_d = DIV_DEN_W'({rec_q.vp_h, 1'b0});
      end
      DS_ADV: begin
        t_d  = (s_hw <<< 1) + s_cw;
        dd_d = DIV_DEN_W'({cfg_i.cell_w, 1'b0});
      end
      default: begin
        t_d  = '0;
        dd_d = DIV_DEN_W'(1);
      end
    endcase
  end

  assign oq_full = (oq_cnt_q == OQCNT_W'(OQ_DEPTH));

  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    div_start = 1'b0;
    oq_push   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          state_d = ST_MUL_RDCH;
        end
      end
      ST_MUL_RDCH:   state_d = ST_MUL_RNCW;
      ST_MUL_RNCW:   state_d = ST_MUL_A;
      ST_MUL_A:      state_d = ST_MUL_B;
      ST_MUL_B:      state_d = ST_MUL_DQ;
      ST_MUL_DQ:     state_d = ST_MUL_HW;
      ST_MUL_HW:     state_d = ST_DIV_SETUP;
      ST_DIV_SETUP:  state_d = ST_DIV_START;
      ST_DIV_START: begin
        div_start = 1'b1;
        state_d   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (sel_q == DS_COL) begin
            state_d = ST_MUL_COLRD;
          end else if (sel_q == DS_ADV) begin
            state_d = ST_PEN;
          end else begin
            state_d = ST_DIV_SETUP;
          end
        end
      end
      ST_MUL_COLRD:  state_d = ST_MUL_COLSRD;
      ST_MUL_COLSRD: state_d = ST_DIV_SETUP;
      ST_PEN:        state_d = ST_EMIT;
      ST_EMIT: begin
        if (!oq_full) begin
          oq_push = 1'b1;
          if (vtx_q == LAST_VTX) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= DS_COL;
      vtx_q   <= '0;
      pen_q   <= '0;
    end else begin
      state_q <= state_d;
      if (q_pop_o) begin
        sel_q <= DS_COL;
        vtx_q <= '0;
        if (q_data_i.line_start) begin
          pen_q <= q_data_i.start_x;
        end
      end
      if ((state_q == ST_DIV_WAIT) && div_done) begin
        sel_q <= div_sel_next(sel_q);
      end
      if (state_q == ST_PEN) begin
        if (pen_sum > 28'sd8388607) begin
          pen_q <= 24'sh7fffff;
        end else if (pen_sum < -28'sd8388608) begin
          pen_q <= 24'sh800000;
        end else begin
          pen_q <= pen_sum[23:0];
        end
      end
      if (oq_push) begin
        vtx_q <= vtx_q + 1'b1;
      end
    end
  end

  assign pen_sum = 28'(pen_q) + 28'(adv_q);

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE:       if (q_pop_o) rec_q <= q_data_i;
      ST_MUL_RDCH:   p_rdch_q <= rd * cfg_i.cell_h;
      ST_MUL_RNCW:   p_rncw_q <= rn * cfg_i.cell_w;
      ST_MUL_A:      p_a_q    <= pen_q * $signed({1'b0, p_rdch_q});
      ST_MUL_B:      p_b_q    <= p_rncw_q * rec_q.glyph_h;
      ST_MUL_DQ:     p_dq_q   <= rec_q.vp_w * p_rdch_q;
      ST_MUL_HW:     p_hw_q   <= rec_q.glyph_h * rec_q.width;
      ST_MUL_COLRD:  p_colrd_q  <= col_q * rd;
      ST_MUL_COLSRD: p_colsrd_q <= cfg_i.cols * rd;
      ST_DIV_SETUP: begin
        t_q  <= t_d;
        dd_q <= dd_d;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          case (sel_q)
            DS_COL: begin
              col_q <= div_rem[8:0];
              row_q <= $signed({2'b0, cfg_i.rows}) - 11'sd1 - $signed({3'b0, div_q[7:0]});
            end
            DS_U0:   u0_q  <= sat_u16(div_q);
            DS_U1:   u1_q  <= sat_u16(div_q);
            DS_V0:   v0_q  <= sat_u16(div_q);
            DS_V1:   v1_q  <= sat_u16(div_q);
            DS_X0:   x0_q  <= sat_s16(div_q);
            DS_X1:   x1_q  <= sat_s16(div_q);
            DS_YB:   yb_q  <= sat_s16(div_q);
            DS_YT:   yt_q  <= sat_s16(div_q);
            DS_ADV:  adv_q <= div_q;
            default: adv_q <= div_q;
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  assign crn = corner_of(vtx_q);

  always_comb begin
    vtx_new.pos_x     = ((crn == 2'd0) || (crn == 2'd3)) ? x0_q : x1_q;
    vtx_new.pos_y     = ((crn == 2'd0) || (crn == 2'd1)) ? yb_q : yt_q;
    vtx_new.tex_u     = ((crn == 2'd0) || (crn == 2'd3)) ? u0_q : u1_q;
    vtx_new.tex_v     = ((crn == 2'd0) || (crn == 2'd1)) ? v0_q : v1_q;
    vtx_new.color     = rec_q.color;
    vtx_new.pen_after = pen_q;
    vtx_new.last      = (vtx_q == LAST_VTX);
  end

  assign empty  = (oq_cnt_q == '0);
  assign oq_pop = pop && !empty;
  assign vtx_o  = oq[oq_rd_q];

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq[oq_wr_q] <= vtx_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      if (oq_push) begin
        oq_wr_q <= oq_wr_q + 1'b1;
      end
      if (oq_pop) begin
        oq_rd_q <= oq_rd_q + 1'b1;
      end
      oq_cnt_q <= oq_cnt_q + OQCNT_W'(oq_push) - OQCNT_W'(oq_pop);
    end
  end

endmodule

FILE: hw/rtl/glyph_quad_generator_top.sv
// Glyph quad generator: turns a stream of character codes into the six vertices of
// one textured quad each. A load beat writes one glyph width and gives no result. A
// draw beat is classified in the front end and queued; the back end then spends almost
// all its time on it in the shared divider, which runs ten divisions of 25 quotient
// bits one after another (plus eight short multiply steps and the issue of the six
// vertices). Up to four draw beats can wait between the two halves, and two vertices
// on the result side. The width table starts undefined: every entry that a draw can
// reach must be loaded first.
// Depends on gqg_pkg, gqg_front, gqg_back.
module glyph_quad_generator_top import gqg_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  push,
  output logic                  full,
  input  logic                  kind_i,
  input  logic [7:0]            char_code_i,
  input  logic [11:0]           width_value_i,
  input  logic                  line_start_i,
  input  logic signed [23:0]    start_x_i,
  input  logic signed [23:0]    start_y_i,
  input  logic [19:0]           glyph_height_i,
  input  logic [31:0]           color_i,
  input  logic [15:0]           viewport_width_i,
  input  logic [15:0]           viewport_height_i,
  output logic                  empty,
  input  logic                  pop,
  output logic signed [15:0]    pos_x_o,
  output logic signed [15:0]    pos_y_o,
  output logic [15:0]           tex_u_o,
  output logic [15:0]           tex_v_o,
  output logic [31:0]           vertex_color_o,
  output logic signed [23:0]    pen_after_o,
  output logic                  last_vertex_o
);

  logic [8:0]  cols_q, rows_q;
  logic [7:0]  first_q, last_q, fallback_q;
  logic        fixed_q;
  logic [11:0] cw_q, ch_q;

  cfg_t    cfg;
  logic    q_valid, q_pop;
  draw_t   q_data;
  vertex_t vtx;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q     <= 9'd16;
      rows_q     <= 9'd16;
      first_q    <= 8'd0;
      last_q     <= 8'd255;
      fallback_q <= 8'd63;
      fixed_q    <= 1'b0;
      cw_q       <= 12'd16;
      ch_q       <= 12'd16;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_ATLAS_COLUMNS: cols_q     <= cfg_data_i[8:0];
        CFG_ATLAS_ROWS:    rows_q     <= cfg_data_i[8:0];
        CFG_FIRST_CODE:    first_q    <= cfg_data_i[7:0];
        CFG_LAST_CODE:     last_q     <= cfg_data_i[7:0];
        CFG_FALLBACK_CODE: fallback_q <= cfg_data_i[7:0];
        CFG_FIXED_WIDTH:   fixed_q    <= cfg_data_i[0];
        CFG_CELL_WIDTH:    cw_q       <= cfg_data_i;
        CFG_CELL_HEIGHT:   ch_q       <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // A zero divisor register behaves as one.
  always_comb begin
    cfg.cols          = (cols_q == '0) ? 9'd1 : cols_q;
    cfg.rows          = (rows_q == '0) ? 9'd1 : rows_q;
    cfg.first_code    = first_q;
    cfg.last_code     = last_q;
    cfg.fallback_code = fallback_q;
    cfg.fixed_width   = fixed_q;
    cfg.cell_w        = (cw_q == '0) ? 12'd1 : cw_q;
    cfg.cell_h        = (ch_q == '0) ? 12'd1 : ch_q;
  end

  gqg_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg),
    .push              (push),
    .full              (full),
    .kind_i            (kind_i),
    .char_code_i       (char_code_i),
    .width_value_i     (width_value_i),
    .line_start_i      (line_start_i),
    .start_x_i         (start_x_i),
    .start_y_i         (start_y_i),
    .glyph_height_i    (glyph_height_i),
    .color_i           (color_i),
    .viewport_width_i  (viewport_width_i),
    .viewport_height_i (viewport_height_i),
    .q_valid_o         (q_valid),
    .q_pop_i           (q_pop),
    .q_data_o          (q_data)
  );

  gqg_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .q_data_i  (q_data),
    .empty     (empty),
    .pop       (pop),
    .vtx_o     (vtx)
  );

  assign pos_x_o        = vtx.pos_x;
  assign pos_y_o        = vtx.pos_y;
  assign tex_u_o        = vtx.tex_u;
  assign tex_v_o        = vtx.tex_v;
  assign vertex_color_o = vtx.color;
  assign pen_after_o    = vtx.pen_after;
  assign last_vertex_o  = vtx.last;

endmodule
